### rtl/core/ica_pkg.sv
package ica_pkg;

   localparam int OPCODE_W = 4;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_ADD = 4'd0;
   localparam logic [OPCODE_W-1:0] OP_SUB = 4'd1;
   localparam logic [OPCODE_W-1:0] OP_MUL = 4'd2;
   localparam logic [OPCODE_W-1:0] OP_DIV = 4'd3;
   localparam logic [OPCODE_W-1:0] OP_POW = 4'd4;
   localparam logic [OPCODE_W-1:0] OP_LCM = 4'd5;
   localparam logic [OPCODE_W-1:0] OP_GCD = 4'd6;
   localparam logic [OPCODE_W-1:0] OP_REM = 4'd7;
   localparam logic [OPCODE_W-1:0] OP_PAR = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DIV0    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVF     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_INVALID = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD_TEST,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MUL_GO,
      S_MUL_WAIT,
      S_POW_STEP,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      UO_WRAP,
      UO_CLAMP,
      UO_DIV
   } unit_op_type;

   typedef enum logic [1:0] {
      MP_MUL,
      MP_LCM,
      MP_POWACC,
      MP_POWSQ
   } mul_phase_type;

   typedef enum logic [1:0] {
      DP_DIV,
      DP_GCD,
      DP_LCMQ
   } div_phase_type;

   typedef struct packed {
      logic        go;
      unit_op_type op;
   } unit_cmd_type;

endpackage

### rtl/core/ica_unit.sv
module ica_unit import ica_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  unit_cmd_type          cmd,
   input  logic [DATA_WIDTH-1:0] x,
   input  logic [DATA_WIDTH-1:0] y,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] low,
   output logic [DATA_WIDTH-1:0] quot
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);
   localparam logic [W:0] OVER = {2'b01, {(W-2){1'b0}}, 1'b1};
   localparam logic [CW-1:0] STEPS = CW'(W);
   localparam logic [CW-1:0] LAST  = CW'(1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   unit_op_type       op_ff, op_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      sh_ff, sh_in;
   logic [W-1:0]      xo_ff, xo_in;
   logic [W:0]        a_op, b_op;
   logic [W+1:0]      sum;
   logic              cin;

   always_comb begin
      if (op_ff == UO_DIV) begin
         a_op = {acc_ff, sh_ff[W-1]};
         b_op = ~{1'b0, xo_ff};
         cin  = 1'b1;
      end else begin
         a_op = {acc_ff, 1'b0};
         b_op = sh_ff[W-1] ? {1'b0, xo_ff} : '0;
         cin  = 1'b0;
      end
      sum = {1'b0, a_op} + {1'b0, b_op} + {{(W+1){1'b0}}, cin};
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      xo_in   = xo_ff;
      if (cmd.go) begin
         run_in = 1'b1;
         cnt_in = STEPS;
         op_in  = cmd.op;
         acc_in = '0;
         sh_in  = (cmd.op == UO_DIV) ? x : y;
         xo_in  = (cmd.op == UO_DIV) ? y : x;
      end else if (run_ff) begin
         cnt_in = cnt_ff - LAST;
         if (cnt_ff == LAST) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
         unique case (op_ff)
            UO_DIV: begin
               acc_in = sum[W+1] ? sum[W-1:0] : a_op[W-1:0];
               sh_in  = {sh_ff[W-2:0], sum[W+1]};
            end
            UO_CLAMP: begin
               acc_in = (sum[W:0] > OVER) ? OVER[W-1:0] : sum[W-1:0];
               sh_in  = {sh_ff[W-2:0], 1'b0};
            end
            default: begin
               acc_in = sum[W-1:0];
               sh_in  = {sh_ff[W-2:0], 1'b0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      xo_ff  <= xo_in;
   end

   assign done = done_ff;
   assign low  = acc_ff;
   assign quot = sh_ff;

endmodule

### rtl/core/integer_calculator_alu.sv
// A command is taken when start is high while busy is low; busy then stays high until the
// result word has been shown on the rsp_ ports for one cycle with rsp_valid high, and the
// receiver must take it in that cycle. Add, subtract and parity are computed as the command
// is taken. Multiply, and divide and remainder by a nonzero divisor, each run one pass of
// the single shared add/subtract unit, which does one bit per cycle. GCD runs one divide
// per Euclid step, LCM adds one divide and one multiply to that, and power runs up to two
// multiplies per exponent bit.
module integer_calculator_alu import ica_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [OPCODE_W-1:0]          req_opcode,
   input  logic signed [DATA_WIDTH-1:0] req_operand_a,
   input  logic signed [DATA_WIDTH-1:0] req_operand_b,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result_value,
   output logic [STATUS_W-1:0]          rsp_status
);

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] SIGN   = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] ONE    = {{(W-1){1'b0}}, 1'b1};
   localparam logic [W-1:0] ALL1   = {W{1'b1}};

   state_type     state_ff, state_in;
   mul_phase_type mph_ff, mph_in;
   div_phase_type dph_ff, dph_in;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [W-1:0]  ra_ff, ra_in, rb_ff, rb_in, ka_ff, ka_in, kb_ff, kb_in;
   logic [W-1:0]  mx_ff, mx_in, my_ff, my_in, pacc_ff, pacc_in, res_ff, res_in;
   logic          neg_ff, neg_in;
   logic [STATUS_W-1:0] st_ff, st_in;

   logic [W-1:0]  a, b, mag_a, mag_ra, mag_rb, e_sh, ux, uy, u_low, u_quot, limit;
   logic          a_bad;
   logic          u_done;
   unit_cmd_type  ucmd;

   assign a      = req_operand_a;
   assign b      = req_operand_b;
   assign mag_a  = a[W-1] ? W'(0) - a : a;
   assign mag_ra = ra_ff[W-1] ? W'(0) - ra_ff : ra_ff;
   assign mag_rb = rb_ff[W-1] ? W'(0) - rb_ff : rb_ff;
   assign e_sh   = rb_ff >> 1;
   assign a_bad  = (a == '0) || (b == '0) || a[W-1] || b[W-1];
   assign limit  = neg_ff ? SIGN : MAXPOS;

   ica_unit #(.DATA_WIDTH(DATA_WIDTH)) u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (ucmd),
      .x     (ux),
      .y     (uy),
      .done  (u_done),
      .low   (u_low),
      .quot  (u_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_opcode)
                  OP_MUL:         state_in = S_MUL_GO;
                  OP_DIV, OP_REM: state_in = (b == '0) ? S_DONE : S_DIV_GO;
                  OP_POW:         state_in = (b == '0 || b[W-1]) ? S_DONE : S_POW_STEP;
                  OP_LCM:         state_in = a_bad ? S_DONE : S_GCD_TEST;
                  OP_GCD:         state_in = S_GCD_TEST;
                  default:        state_in = S_DONE;
               endcase
            end
         end
         S_GCD_TEST: state_in = (rb_ff == '0 && op_ff == OP_GCD) ? S_DONE : S_DIV_GO;
         S_DIV_GO:   state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (u_done) begin
               unique case (dph_ff)
                  DP_DIV:  state_in = S_DONE;
                  DP_GCD:  state_in = S_GCD_TEST;
                  default: state_in = S_MUL_GO;
               endcase
            end
         end
         S_MUL_GO:   state_in = S_MUL_WAIT;
         S_MUL_WAIT: begin
            if (u_done) begin
               unique case (mph_ff)
                  MP_POWACC: state_in = (e_sh == '0) ? S_DONE : S_MUL_GO;
                  MP_POWSQ:  state_in = S_POW_STEP;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_POW_STEP: state_in = S_MUL_GO;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
      ucmd.go   = (state_ff == S_MUL_GO) || (state_ff == S_DIV_GO);
      if (state_ff == S_DIV_GO) begin
         ucmd.op = UO_DIV;
         ux      = mag_ra;
         uy      = mag_rb;
      end else begin
         ucmd.op = (mph_ff == MP_MUL) ? UO_WRAP : UO_CLAMP;
         ux      = mx_ff;
         uy      = my_ff;
      end
   end

   always_comb begin
      op_in   = op_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      ka_in   = ka_ff;
      kb_in   = kb_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      pacc_in = pacc_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      st_in   = st_ff;
      mph_in  = mph_ff;
      dph_in  = dph_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in  = req_opcode;
               ra_in  = a;
               rb_in  = b;
               ka_in  = a;
               kb_in  = b;
               res_in = '0;
               st_in  = ST_OK;
               unique case (req_opcode)
                  OP_ADD: res_in = a + b;
                  OP_SUB: res_in = a - b;
                  OP_MUL: begin
                     mx_in  = a;
                     my_in  = b;
                     mph_in = MP_MUL;
                  end
                  OP_DIV, OP_REM: begin
                     dph_in = DP_DIV;
                     if (b == '0) begin
                        st_in = ST_DIV0;
                     end
                  end
                  OP_POW: begin
                     if (b == '0) begin
                        res_in = ONE;
                     end else if (b[W-1]) begin
                        if (a == '0) begin
                           st_in = ST_DIV0;
                        end else if (a == ONE) begin
                           res_in = ONE;
                        end else if (a == ALL1) begin
                           res_in = b[0] ? ALL1 : ONE;
                        end
                     end else begin
                        ra_in   = mag_a;
                        pacc_in = ONE;
                        neg_in  = a[W-1] & b[0];
                     end
                  end
                  OP_LCM: begin
                     if (a_bad) begin
                        st_in = ST_INVALID;
                     end
                  end
                  OP_GCD: res_in = '0;
                  OP_PAR: res_in = {{(W-1){1'b0}}, a[0]};
                  default: st_in = ST_INVALID;
               endcase
            end
         end
         S_GCD_TEST: begin
            if (rb_ff == '0) begin
               if (op_ff == OP_GCD) begin
                  res_in = ra_ff;
               end else begin
                  ra_in  = ka_ff;
                  rb_in  = ra_ff;
                  dph_in = DP_LCMQ;
               end
            end else begin
               dph_in = DP_GCD;
            end
         end
         S_DIV_WAIT: begin
            if (u_done) begin
               unique case (dph_ff)
                  DP_DIV: begin
                     if (op_ff == OP_REM) begin
                        res_in = ra_ff[W-1] ? W'(0) - u_low : u_low;
                     end else if (!(ra_ff[W-1] ^ rb_ff[W-1]) && u_quot[W-1]) begin
                        res_in = MAXPOS;
                        st_in  = ST_OVF;
                     end else begin
                        res_in = (ra_ff[W-1] ^ rb_ff[W-1]) ? W'(0) - u_quot : u_quot;
                     end
                  end
                  DP_GCD: begin
                     ra_in = rb_ff;
                     rb_in = ra_ff[W-1] ? W'(0) - u_low : u_low;
                  end
                  default: begin
                     mx_in  = u_quot;
                     my_in  = kb_ff;
                     mph_in = MP_LCM;
                  end
               endcase
            end
         end
         S_MUL_WAIT: begin
            if (u_done) begin
               unique case (mph_ff)
                  MP_MUL: res_in = u_low;
                  MP_LCM: begin
                     if (u_low > MAXPOS) begin
                        res_in = MAXPOS;
                        st_in  = ST_OVF;
                     end else begin
                        res_in = u_low;
                     end
                  end
                  MP_POWACC: begin
                     pacc_in = u_low;
                     rb_in   = e_sh;
                     mx_in   = ra_ff;
                     my_in   = ra_ff;
                     mph_in  = MP_POWSQ;
                     if (u_low > limit) begin
                        res_in = limit;
                        st_in  = ST_OVF;
                     end else begin
                        res_in = neg_ff ? W'(0) - u_low : u_low;
                     end
                  end
                  default: ra_in = u_low;
               endcase
            end
         end
         S_POW_STEP: begin
            if (rb_ff[0]) begin
               mx_in  = pacc_ff;
               my_in  = ra_ff;
               mph_in = MP_POWACC;
            end else begin
               rb_in  = e_sh;
               mx_in  = ra_ff;
               my_in  = ra_ff;
               mph_in = MP_POWSQ;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      ra_ff   <= ra_in;
      rb_ff   <= rb_in;
      ka_ff   <= ka_in;
      kb_ff   <= kb_in;
      mx_ff   <= mx_in;
      my_ff   <= my_in;
      pacc_ff <= pacc_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
      st_ff   <= st_in;
      mph_ff  <= mph_in;
      dph_ff  <= dph_in;
   end

   assign rsp_result_value = res_ff;
   assign rsp_status       = st_ff;

endmodule

### rtl/core/ica_checker.sv
module ica_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // A result word appears only while a command is in flight.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result word outside a command");

   // An accepted command makes the block busy.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("command accepted but block not busy");

   // Each command yields one result word, after which the block is free again.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result word repeated");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("block still busy after its result word");

endmodule

bind integer_calculator_alu ica_checker u_ica_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
